>>> src/onewire_bus_master_defines.svh
// Assertion macros shared by the one-wire bus master RTL.
// Needs clk and rst_n in the scope of each use.
`ifndef ONEWIRE_BUS_MASTER_DEFINES_SVH
`define ONEWIRE_BUS_MASTER_DEFINES_SVH

// Check an expression on every clock edge out of reset.
`define OWBM_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("owbm: invariant violated");

// Check a consequence in the same cycle.
`define OWBM_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("owbm: same-cycle check failed");

// Check a consequence in the following cycle.
`define OWBM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("owbm: next-cycle check failed");

`endif

>>> src/owbm_pkg.sv
// Types and constants of the one-wire bus master.
// No dependencies; used by owbm_seq and onewire_bus_master.
package owbm_pkg;

    localparam int CFG_W    = 10;
    localparam int BYTE_W   = 8;
    localparam int CMD_W    = 3;
    localparam int CFG_IDX_W = 3;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_RESET      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE_BIT  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_READ_BIT   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_WRITE_BYTE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ_BYTE  = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_WAIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_TAIL    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT          = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_ONE_LOW = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_LOW      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_SAMPLE   = 3'd7;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_RST_LOW  = 4'd1,
        PH_RST_WAIT = 4'd2,
        PH_RST_TAIL = 4'd3,
        PH_WR_LOW   = 4'd4,
        PH_WR_HIGH  = 4'd5,
        PH_WR_REC   = 4'd6,
        PH_RD_LOW   = 4'd7,
        PH_RD_WAIT  = 4'd8,
        PH_RD_TAIL  = 4'd9
    } phase_t;

    typedef struct packed {
        logic [CFG_W-1:0] reset_low_us;
        logic [CFG_W-1:0] presence_wait_us;
        logic [CFG_W-1:0] reset_tail_us;
        logic [CFG_W-1:0] slot_us;
        logic [CFG_W-1:0] write_one_low_us;
        logic [CFG_W-1:0] recovery_us;
        logic [CFG_W-1:0] read_low_us;
        logic [CFG_W-1:0] read_sample_us;
    } cfg_t;

    typedef struct packed {
        logic              tick;
        logic              line_level;
        logic              cmd_valid;
        logic [CMD_W-1:0]  command;
        logic [BYTE_W-1:0] write_data;
    } item_t;

    typedef struct packed {
        logic              drive_low;
        logic              busy_res;
        logic              done_res;
        logic              presence;
        logic [BYTE_W-1:0] read_data;
    } result_t;

endpackage

>>> src/owbm_seq.sv
// Bus timing sequencer: phase state, delay counter, bit shifter.
// Depends on owbm_pkg and onewire_bus_master_defines.svh.
`include "onewire_bus_master_defines.svh"

module owbm_seq #(
    parameter int TIMER_BITS = 10
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  owbm_pkg::item_t   item,
    input  owbm_pkg::cfg_t    cfg,
    output owbm_pkg::result_t result
);

    localparam int LW = (TIMER_BITS > owbm_pkg::CFG_W) ? TIMER_BITS : owbm_pkg::CFG_W;
    localparam logic [LW-1:0] CNT_MAX = LW'({TIMER_BITS{1'b1}});

    owbm_pkg::phase_t                  phase_reg, phase_next;
    logic [TIMER_BITS-1:0]             cnt_reg, cnt_next;
    logic [3:0]                        bit_index_reg, bit_index_next;
    logic [owbm_pkg::BYTE_W-1:0]       shift_reg, shift_next;
    logic [owbm_pkg::CMD_W-1:0]        active_cmd_reg, active_cmd_next;
    logic                              presence_reg, presence_next;
    logic                              done;

    logic                              cur_bit;
    logic [owbm_pkg::CFG_W-1:0]        len_raw;
    logic [LW-1:0]                     len_wide;
    logic [TIMER_BITS-1:0]             len;
    logic [TIMER_BITS-1:0]             cnt_after;
    logic                              phase_end;
    logic [3:0]                        bit_inc;
    logic [3:0]                        bits_needed;

    function automatic logic [owbm_pkg::CFG_W-1:0] sat_sub(
        input logic [owbm_pkg::CFG_W-1:0] a,
        input logic [owbm_pkg::CFG_W-1:0] b
    );
        return (a > b) ? a - b : '0;
    endfunction

    // Pick the length of the current phase and clip it to the counter
    always_comb
    begin
        cur_bit = shift_reg[bit_index_reg[2:0]];
        case (phase_reg)
            owbm_pkg::PH_RST_LOW:  len_raw = cfg.reset_low_us;
            owbm_pkg::PH_RST_WAIT: len_raw = cfg.presence_wait_us;
            owbm_pkg::PH_RST_TAIL: len_raw = cfg.reset_tail_us;
            owbm_pkg::PH_WR_LOW:   len_raw = cur_bit ? cfg.write_one_low_us : cfg.slot_us;
            owbm_pkg::PH_WR_HIGH:  len_raw = sat_sub(cfg.slot_us, cfg.write_one_low_us);
            owbm_pkg::PH_WR_REC:   len_raw = cfg.recovery_us;
            owbm_pkg::PH_RD_LOW:   len_raw = cfg.read_low_us;
            owbm_pkg::PH_RD_WAIT:  len_raw = cfg.read_sample_us;
            owbm_pkg::PH_RD_TAIL:  len_raw = sat_sub(cfg.slot_us, cfg.read_sample_us);
            default:               len_raw = '0;
        endcase
        len_wide = LW'(len_raw);
        len = (len_wide > CNT_MAX) ? CNT_MAX[TIMER_BITS-1:0] : len_wide[TIMER_BITS-1:0];
    end

    // Advance the delay counter and detect the end of the phase
    always_comb
    begin
        cnt_after = (item.tick && (cnt_reg < len)) ? cnt_reg + TIMER_BITS'(1) : cnt_reg;
        phase_end = (cnt_after >= len);
        bit_inc = bit_index_reg + 4'd1;
        bits_needed = ((active_cmd_reg == owbm_pkg::CMD_WRITE_BYTE) ||
                       (active_cmd_reg == owbm_pkg::CMD_READ_BYTE)) ?
                      owbm_pkg::BITS_PER_BYTE : 4'd1;
    end

    // Next state
    always_comb
    begin
        phase_next      = phase_reg;
        cnt_next        = cnt_reg;
        bit_index_next  = bit_index_reg;
        shift_next      = shift_reg;
        active_cmd_next = active_cmd_reg;
        presence_next   = presence_reg;
        done            = 1'b0;
        if (phase_reg == owbm_pkg::PH_IDLE)
        begin
            if (item.cmd_valid &&
                (item.command inside {[owbm_pkg::CMD_RESET:owbm_pkg::CMD_READ_BYTE]}))
            begin
                active_cmd_next = item.command;
                cnt_next        = '0;
                bit_index_next  = '0;
                case (item.command)
                    owbm_pkg::CMD_RESET:
                        phase_next = owbm_pkg::PH_RST_LOW;
                    owbm_pkg::CMD_WRITE_BIT:
                    begin
                        shift_next = {{(owbm_pkg::BYTE_W-1){1'b0}}, item.write_data[0]};
                        phase_next = owbm_pkg::PH_WR_LOW;
                    end
                    owbm_pkg::CMD_WRITE_BYTE:
                    begin
                        shift_next = item.write_data;
                        phase_next = owbm_pkg::PH_WR_LOW;
                    end
                    default:
                    begin
                        shift_next = '0;
                        phase_next = owbm_pkg::PH_RD_LOW;
                    end
                endcase
            end
        end
        else
        begin
            cnt_next = cnt_after;
            if (phase_end)
            begin
                cnt_next = '0;
                case (phase_reg)
                    owbm_pkg::PH_RST_LOW:
                        phase_next = owbm_pkg::PH_RST_WAIT;
                    owbm_pkg::PH_RST_WAIT:
                    begin
                        presence_next = ~item.line_level;
                        phase_next    = owbm_pkg::PH_RST_TAIL;
                    end
                    owbm_pkg::PH_WR_LOW:
                        phase_next = cur_bit ? owbm_pkg::PH_WR_HIGH : owbm_pkg::PH_WR_REC;
                    owbm_pkg::PH_WR_HIGH:
                        phase_next = owbm_pkg::PH_WR_REC;
                    owbm_pkg::PH_RD_LOW:
                        phase_next = owbm_pkg::PH_RD_WAIT;
                    owbm_pkg::PH_RD_WAIT:
                    begin
                        if (item.line_level)
                            shift_next = shift_reg |
                                (owbm_pkg::BYTE_W'(1) << bit_index_reg[2:0]);
                        phase_next = owbm_pkg::PH_RD_TAIL;
                    end
                    owbm_pkg::PH_WR_REC, owbm_pkg::PH_RD_TAIL:
                    begin
                        bit_index_next = bit_inc;
                        if (bit_inc >= bits_needed)
                        begin
                            phase_next = owbm_pkg::PH_IDLE;
                            done       = 1'b1;
                        end
                        else if (phase_reg == owbm_pkg::PH_WR_REC)
                            phase_next = owbm_pkg::PH_WR_LOW;
                        else
                            phase_next = owbm_pkg::PH_RD_LOW;
                    end
                    default:
                    begin
                        // reset tail ends the command
                        phase_next = owbm_pkg::PH_IDLE;
                        done       = 1'b1;
                    end
                endcase
            end
        end
    end

    // Result word from the updated state
    always_comb
    begin
        result.drive_low = (phase_next == owbm_pkg::PH_RST_LOW) ||
                           (phase_next == owbm_pkg::PH_WR_LOW) ||
                           (phase_next == owbm_pkg::PH_RD_LOW);
        result.busy_res  = (phase_next != owbm_pkg::PH_IDLE);
        result.done_res  = done;
        result.presence  = presence_next;
        result.read_data = ((active_cmd_next == owbm_pkg::CMD_READ_BIT) ||
                            (active_cmd_next == owbm_pkg::CMD_READ_BYTE)) ? shift_next : '0;
    end

    // Hold state between accepted words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= owbm_pkg::PH_IDLE;
            cnt_reg        <= '0;
            bit_index_reg  <= '0;
            shift_reg      <= '0;
            active_cmd_reg <= owbm_pkg::CMD_RESET;
            presence_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            cnt_reg        <= cnt_next;
            bit_index_reg  <= bit_index_next;
            shift_reg      <= shift_next;
            active_cmd_reg <= active_cmd_next;
            presence_reg   <= presence_next;
        end
    end

    `OWBM_ASSERT_IMPL(a_idle_cnt_clear, phase_reg == owbm_pkg::PH_IDLE, cnt_reg == '0)
    `OWBM_ASSERT_ALWAYS(a_bit_index_range, bit_index_reg <= owbm_pkg::BITS_PER_BYTE)
    `OWBM_ASSERT_IMPL(a_cnt_within_len, phase_reg != owbm_pkg::PH_IDLE, cnt_reg <= len)

endmodule

>>> src/onewire_bus_master.sv
// One-wire bus master top level: configuration registers, sequencer, output buffer.
// Depends on owbm_pkg, owbm_seq and onewire_bus_master_defines.svh.
//
//  channel   direction  handshake                 word
//  item      in         item_valid / item_stall   owbm_pkg::item_t
//  result    out        result_valid / result_stall owbm_pkg::result_t
//  cfg       in         cfg_valid / cfg_ready     cfg_index (3 b), cfg_data (10 b)
//
// One item per cycle unless item_stall holds it; each item gives one result word.
// The sequencer updates its state in the accepting cycle; a two-word output buffer
// (result register plus skid register) keeps input flowing while a result waits.
// item_stall rises only when both output words are held by result_stall.
// rst_n is asynchronous: configuration returns to its defaults, sequencer goes idle.
`include "onewire_bus_master_defines.svh"

module onewire_bus_master #(
    parameter int TIMER_BITS = 10
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_stall,
    input  owbm_pkg::item_t                    item,
    output logic                               result_valid,
    input  logic                               result_stall,
    output owbm_pkg::result_t                  result,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [owbm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [owbm_pkg::CFG_W-1:0]         cfg_data
);

    owbm_pkg::cfg_t     cfg_reg, cfg_next;
    owbm_pkg::result_t  seq_result;
    owbm_pkg::result_t  out_word_reg, out_word_next;
    owbm_pkg::result_t  skid_word_reg, skid_word_next;
    logic               out_valid_reg, out_valid_next;
    logic               skid_valid_reg, skid_valid_next;
    logic               accept;
    logic               take;

    assign cfg_ready    = 1'b1;
    assign item_stall   = skid_valid_reg;
    assign accept       = item_valid && !skid_valid_reg;
    assign take         = out_valid_reg && !result_stall;
    assign result_valid = out_valid_reg;
    assign result       = out_word_reg;

    // Decode configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                owbm_pkg::CFG_RESET_LOW:     cfg_next.reset_low_us     = cfg_data;
                owbm_pkg::CFG_PRESENCE_WAIT: cfg_next.presence_wait_us = cfg_data;
                owbm_pkg::CFG_RESET_TAIL:    cfg_next.reset_tail_us    = cfg_data;
                owbm_pkg::CFG_SLOT:          cfg_next.slot_us          = cfg_data;
                owbm_pkg::CFG_WRITE_ONE_LOW: cfg_next.write_one_low_us = cfg_data;
                owbm_pkg::CFG_RECOVERY:      cfg_next.recovery_us      = cfg_data;
                owbm_pkg::CFG_READ_LOW:      cfg_next.read_low_us      = cfg_data;
                owbm_pkg::CFG_READ_SAMPLE:   cfg_next.read_sample_us   = cfg_data;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_low_us     <= 10'd480;
            cfg_reg.presence_wait_us <= 10'd100;
            cfg_reg.reset_tail_us    <= 10'd380;
            cfg_reg.slot_us          <= 10'd60;
            cfg_reg.write_one_low_us <= 10'd5;
            cfg_reg.recovery_us      <= 10'd2;
            cfg_reg.read_low_us      <= 10'd2;
            cfg_reg.read_sample_us   <= 10'd5;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    owbm_seq #(
        .TIMER_BITS (TIMER_BITS)
    ) u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .cfg    (cfg_reg),
        .result (seq_result)
    );

    // Steer the new result word into the output or skid register
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_word_next   = out_word_reg;
        skid_valid_next = skid_valid_reg;
        skid_word_next  = skid_word_reg;
        if (take)
        begin
            if (skid_valid_reg)
            begin
                out_word_next   = skid_word_reg;
                skid_valid_next = 1'b0;
            end
            else if (accept)
                out_word_next = seq_result;
            else
                out_valid_next = 1'b0;
        end
        else if (accept)
        begin
            if (!out_valid_reg)
            begin
                out_word_next  = seq_result;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_word_next  = seq_result;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload registers carry no reset
    always_ff @(posedge clk)
    begin
        out_word_reg  <= out_word_next;
        skid_word_reg <= skid_word_next;
    end

    `OWBM_ASSERT_IMPL(a_skid_needs_out, skid_valid_reg, out_valid_reg)
    `OWBM_ASSERT_NEXT(a_stalled_word_kept, out_valid_reg && result_stall, out_valid_reg)
    `OWBM_ASSERT_NEXT(a_overflow_to_skid, accept && out_valid_reg && result_stall, skid_valid_reg)

endmodule

>>> sim/onewire_bus_master_tb.sv
// Self-checking testbench for the one-wire bus master: directed table, then random phases.
// Depends on owbm_pkg and the onewire_bus_master RTL; reads no files, needs no arguments.
module onewire_bus_master_tb;

    import owbm_pkg::*;

    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int N_PHASES        = 10;

    localparam cfg_t CFG_DEFAULTS = '{10'd480, 10'd100, 10'd380, 10'd60,
                                      10'd5, 10'd2, 10'd2, 10'd5};

    // One row of the directed table: a word, how often to send it, and an optional
    // hand-written expectation
    typedef struct packed {
        item_t      stim;
        logic [7:0] reps;
        logic       typed;
        result_t    want;
    } stim_row_t;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 item_valid   = 1'b0;
    logic                 item_stall;
    item_t                item_word    = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    result_t              result_word;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index    = CFG_RESET_LOW;
    logic [CFG_W-1:0]     cfg_data     = '0;

    // Sequencer model state
    cfg_t              timing;
    phase_t            seq_phase;
    logic [CFG_W-1:0]  delay_cnt;
    logic [3:0]        bit_pos;
    logic [BYTE_W-1:0] shift_byte;
    logic [CMD_W-1:0]  cur_cmd;
    logic              presence_seen;

    result_t expected_words [$];
    result_t head_word;
    int      err_count    = 0;
    int      n_results    = 0;
    int      quiet_cycles = 0;
    int      gap_pct      = 0;
    int      stall_pct    = 0;

    // Zero timing for the table, so every phase ends on the next word without a tick
    stim_row_t dir_rows [16] = '{
        '{'{1'b0, 1'b0, 1'b0, CMD_RESET, 8'h00}, 8'd1, 1'b1, '0},
        '{'{1'b1, 1'b1, 1'b1, CMD_READ_BYTE + 3'd1, 8'hFF}, 8'd1, 1'b1, '0},
        '{'{1'b0, 1'b0, 1'b1, CMD_READ_BYTE + 3'd2, 8'h5A}, 8'd1, 1'b1, '0},
        '{'{1'b1, 1'b0, 1'b1, CMD_READ_BYTE + 3'd3, 8'h00}, 8'd1, 1'b1, '0},
        '{'{1'b0, 1'b1, 1'b1, CMD_RESET, 8'h00}, 8'd1, 1'b0, '0},
        '{'{1'b1, 1'b0, 1'b1, CMD_WRITE_BYTE, 8'hFF}, 8'd3, 1'b0, '0},
        '{'{1'b0, 1'b0, 1'b1, CMD_READ_BIT, 8'h00}, 8'd1, 1'b0, '0},
        '{'{1'b0, 1'b0, 1'b0, CMD_RESET, 8'h00}, 8'd3, 1'b0, '0},
        '{'{1'b0, 1'b1, 1'b1, CMD_RESET, 8'h00}, 8'd1, 1'b0, '0},
        '{'{1'b1, 1'b1, 1'b0, CMD_RESET, 8'h00}, 8'd3, 1'b0, '0},
        '{'{1'b1, 1'b0, 1'b1, CMD_WRITE_BIT, 8'hFF}, 8'd1, 1'b0, '0},
        '{'{1'b1, 1'b0, 1'b0, CMD_RESET, 8'h00}, 8'd3, 1'b0, '0},
        '{'{1'b1, 1'b0, 1'b1, CMD_WRITE_BYTE, 8'hA5}, 8'd1, 1'b0, '0},
        '{'{1'b1, 1'b1, 1'b0, CMD_RESET, 8'h00}, 8'd20, 1'b0, '0},
        '{'{1'b1, 1'b1, 1'b1, CMD_READ_BYTE, 8'h00}, 8'd1, 1'b0, '0},
        '{'{1'b1, 1'b1, 1'b0, CMD_RESET, 8'h00}, 8'd24, 1'b0, '0}
    };

    onewire_bus_master dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item_word),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result_word),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic void reset_model();
        timing        = CFG_DEFAULTS;
        seq_phase     = PH_IDLE;
        delay_cnt     = '0;
        bit_pos       = '0;
        shift_byte    = '0;
        cur_cmd       = CMD_RESET;
        presence_seen = 1'b0;
    endfunction

    // Length of the current timed phase; slot remainders saturate at zero
    function automatic logic [CFG_W-1:0] phase_span();
        logic cur_bit;
        cur_bit = shift_byte[bit_pos[2:0]];
        case (seq_phase)
            PH_RST_LOW:  return timing.reset_low_us;
            PH_RST_WAIT: return timing.presence_wait_us;
            PH_RST_TAIL: return timing.reset_tail_us;
            PH_WR_LOW:   return cur_bit ? timing.write_one_low_us : timing.slot_us;
            PH_WR_HIGH:  return (timing.slot_us > timing.write_one_low_us) ?
                                timing.slot_us - timing.write_one_low_us : '0;
            PH_WR_REC:   return timing.recovery_us;
            PH_RD_LOW:   return timing.read_low_us;
            PH_RD_WAIT:  return timing.read_sample_us;
            PH_RD_TAIL:  return (timing.slot_us > timing.read_sample_us) ?
                                timing.slot_us - timing.read_sample_us : '0;
            default:     return '0;
        endcase
    endfunction

    // Advance the sequencer by one word and return the status it shows afterwards
    function automatic result_t sequencer_next(input item_t it);
        logic [CFG_W-1:0] span;
        logic             finished;
        logic [3:0]       bits_wanted;
        result_t          r;
        finished = 1'b0;
        if (seq_phase == PH_IDLE)
        begin
            // Start a known command; its first phase does no timing on this word
            if (it.cmd_valid && it.command <= CMD_READ_BYTE)
            begin
                cur_cmd   = it.command;
                delay_cnt = '0;
                bit_pos   = '0;
                case (it.command)
                    CMD_RESET:
                        seq_phase = PH_RST_LOW;
                    CMD_WRITE_BIT:
                    begin
                        shift_byte = {7'b0, it.write_data[0]};
                        seq_phase  = PH_WR_LOW;
                    end
                    CMD_WRITE_BYTE:
                    begin
                        shift_byte = it.write_data;
                        seq_phase  = PH_WR_LOW;
                    end
                    default:
                    begin
                        shift_byte = '0;
                        seq_phase  = PH_RD_LOW;
                    end
                endcase
            end
        end
        else
        begin
            span = phase_span();
            if (it.tick && delay_cnt < span)
                delay_cnt = delay_cnt + 1'b1;
            if (delay_cnt >= span)
            begin
                delay_cnt = '0;
                case (seq_phase)
                    PH_RST_LOW:
                        seq_phase = PH_RST_WAIT;
                    PH_RST_WAIT:
                    begin
                        presence_seen = !it.line_level;
                        seq_phase     = PH_RST_TAIL;
                    end
                    PH_WR_LOW:
                        seq_phase = shift_byte[bit_pos[2:0]] ? PH_WR_HIGH : PH_WR_REC;
                    PH_WR_HIGH:
                        seq_phase = PH_WR_REC;
                    PH_RD_LOW:
                        seq_phase = PH_RD_WAIT;
                    PH_RD_WAIT:
                    begin
                        if (it.line_level)
                            shift_byte[bit_pos[2:0]] = 1'b1;
                        seq_phase = PH_RD_TAIL;
                    end
                    PH_WR_REC, PH_RD_TAIL:
                    begin
                        bits_wanted = (cur_cmd == CMD_WRITE_BYTE || cur_cmd == CMD_READ_BYTE) ?
                                      BITS_PER_BYTE : 4'd1;
                        bit_pos = bit_pos + 1'b1;
                        if (bit_pos >= bits_wanted)
                        begin
                            seq_phase = PH_IDLE;
                            finished  = 1'b1;
                        end
                        else if (seq_phase == PH_WR_REC)
                            seq_phase = PH_WR_LOW;
                        else
                            seq_phase = PH_RD_LOW;
                    end
                    default:
                    begin
                        seq_phase = PH_IDLE;
                        finished  = 1'b1;
                    end
                endcase
            end
        end
        r.drive_low = (seq_phase == PH_RST_LOW) || (seq_phase == PH_WR_LOW) ||
                      (seq_phase == PH_RD_LOW);
        r.busy_res  = (seq_phase != PH_IDLE);
        r.done_res  = finished;
        r.presence  = presence_seen;
        r.read_data = (cur_cmd == CMD_READ_BIT || cur_cmd == CMD_READ_BYTE) ? shift_byte : '0;
        return r;
    endfunction

    // Pick a random word: mostly real commands while idle, ticks and noise while busy
    function automatic item_t gen_item();
        item_t it;
        int    pick;
        it.tick       = ($urandom_range(99) < 85);
        it.line_level = 1'($urandom_range(1));
        it.write_data = 8'($urandom_range(255));
        it.command    = 3'($urandom_range(7));
        if (seq_phase == PH_IDLE)
        begin
            pick         = $urandom_range(99);
            it.cmd_valid = (pick >= 6);
            if (pick < 6)
                ;
            else if (pick < 14)
                it.command = CMD_READ_BYTE + 3'($urandom_range(1, 3));
            else if (pick < 30)
                it.command = CMD_RESET;
            else if (pick < 46)
                it.command = CMD_WRITE_BIT;
            else if (pick < 62)
                it.command = CMD_READ_BIT;
            else if (pick < 81)
                it.command = CMD_WRITE_BYTE;
            else
                it.command = CMD_READ_BYTE;
        end
        else
            it.cmd_valid = ($urandom_range(99) < 25);
        return it;
    endfunction

    // Timing set for each random phase; odd phases draw very short lengths, then phases 0 to 3 get fixed overrides
    function automatic cfg_t phase_cfg(input int k);
        cfg_t c;
        int   top;
        top                = (k % 2) ? 3 : 12;
        c.reset_low_us     = CFG_W'($urandom_range(top));
        c.presence_wait_us = CFG_W'($urandom_range(top));
        c.reset_tail_us    = CFG_W'($urandom_range(top));
        c.slot_us          = CFG_W'($urandom_range(top));
        c.write_one_low_us = CFG_W'($urandom_range(top));
        c.recovery_us      = CFG_W'($urandom_range(top));
        c.read_low_us      = CFG_W'($urandom_range(top));
        c.read_sample_us   = CFG_W'($urandom_range(top));
        case (k)
            0: c = CFG_DEFAULTS;
            // longest reset pulse the register holds; the counter runs full
            1: c.reset_low_us = '1;
            2: c = '0;
            3:
            begin
                // slot shorter than both the write-one pulse and the read sample point
                c.slot_us          = 10'd3;
                c.write_one_low_us = 10'd9;
                c.read_sample_us   = 10'd12;
            end
            default: ;
        endcase
        return c;
    endfunction

    function automatic void set_pressure(input int mode);
        case (mode)
            1:       begin gap_pct = 59; stall_pct = 0;  end
            2:       begin gap_pct = 0;  stall_pct = 59; end
            3:       begin gap_pct = 22; stall_pct = 22; end
            default: begin gap_pct = 0;  stall_pct = 0;  end
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR: %s", msg);
        err_count++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                      n_results, name, got, want));
    endtask

    // Present one word, hold it until taken, then log what it should produce
    task automatic send_item(input item_t it, input logic typed, input result_t want);
        result_t pred;
        if (gap_pct != 0 && $urandom_range(99) < gap_pct)
        begin
            item_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < gap_pct);
        end
        item_valid <= 1'b1;
        item_word  <= it;
        do @(posedge clk); while (item_stall);
        pred = sequencer_next(it);
        expected_words.push_back(typed ? want : pred);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_RESET_LOW:     timing.reset_low_us     = val;
            CFG_PRESENCE_WAIT: timing.presence_wait_us = val;
            CFG_RESET_TAIL:    timing.reset_tail_us    = val;
            CFG_SLOT:          timing.slot_us          = val;
            CFG_WRITE_ONE_LOW: timing.write_one_low_us = val;
            CFG_RECOVERY:      timing.recovery_us      = val;
            CFG_READ_LOW:      timing.read_low_us      = val;
            default:           timing.read_sample_us   = val;
        endcase
    endtask

    // Run the current command out, let every result drain, then rewrite all timing
    task automatic load_config(input cfg_t c);
        while (seq_phase != PH_IDLE)
            send_item(gen_item(), 1'b0, '0);
        item_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        write_reg(CFG_RESET_LOW,     c.reset_low_us);
        write_reg(CFG_PRESENCE_WAIT, c.presence_wait_us);
        write_reg(CFG_RESET_TAIL,    c.reset_tail_us);
        write_reg(CFG_SLOT,          c.slot_us);
        write_reg(CFG_WRITE_ONE_LOW, c.write_one_low_us);
        write_reg(CFG_RECOVERY,      c.recovery_us);
        write_reg(CFG_READ_LOW,      c.read_low_us);
        write_reg(CFG_READ_SAMPLE,   c.read_sample_us);
        cfg_valid <= 1'b0;
    endtask

    // Stall the result channel at random and check each taken word against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            result_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
            if (result_valid && !result_stall)
            begin
                if (expected_words.size() == 0)
                    report_mismatch($sformatf("result %0d arrived with nothing expected",
                                              n_results));
                else
                begin
                    head_word = expected_words.pop_front();
                    check_field("drive_low", 8'(result_word.drive_low),
                                8'(head_word.drive_low));
                    check_field("busy_res",  8'(result_word.busy_res),
                                8'(head_word.busy_res));
                    check_field("done_res",  8'(result_word.done_res),
                                8'(head_word.done_res));
                    check_field("presence",  8'(result_word.presence),
                                8'(head_word.presence));
                    check_field("read_data", result_word.read_data, head_word.read_data);
                end
                n_results++;
            end
        end
    end

    // Abort when no channel moves a word for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
                (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int k;
        int i;
        reset_model();
        set_pressure(0);
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table under all-zero timing
        load_config('0);
        foreach (dir_rows[r])
            repeat (dir_rows[r].reps)
                send_item(dir_rows[r].stim, dir_rows[r].typed, dir_rows[r].want);

        // Random phases, each with its own timing and idling pattern
        for (k = 0; k < N_PHASES; k++)
        begin
            load_config(phase_cfg(k));
            set_pressure(k % 4);
            for (i = 0; i < ITEMS_PER_PHASE; i++)
                send_item(gen_item(), 1'b0, '0);
        end

        // Finish the last command and drain
        while (seq_phase != PH_IDLE)
            send_item(gen_item(), 1'b0, '0);
        item_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        if (err_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
